// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Implication whose consequent is checked in the next cycle.
`define ASSERT_IMPLY_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== design/hll_pkg.sv =====
package hll_pkg;

    localparam int HASH_W    = 64;
    localparam int RANK_W    = 6;
    localparam int BKT_OUT_W = 11;
    localparam int SUM_OUT_W = 59;
    localparam int CNT_OUT_W = 12;
    localparam int M_TDATA_W = 96;

    // Result word, first field in the highest bits.
    typedef struct packed {
        logic [CNT_OUT_W-1:0] empty_count;
        logic [SUM_OUT_W-1:0] harmonic_sum;
        logic                 rank_raised;
        logic [RANK_W-1:0]    new_rank;
        logic [BKT_OUT_W-1:0] bucket_index;
    } result_t;

    localparam int RES_W = $bits(result_t);
    localparam int PAD_W = M_TDATA_W - RES_W;

endpackage

// ===== design/hll_ram.sv =====
module hll_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/hll_front.sv =====
module hll_front #(
    parameter int BUCKET_BITS = 11
) (
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [hll_pkg::HASH_W-1:0] s_tdata,
    input  logic                       queue_full,
    input  logic                       clearing,
    output logic                       push,
    output logic [BUCKET_BITS-1:0]     push_bucket,
    output logic [hll_pkg::RANK_W-1:0] push_rank
);

    localparam int REST_W = hll_pkg::HASH_W - BUCKET_BITS;

    logic [hll_pkg::HASH_W-1:0] rest;
    logic [7:0]                 chunk_nz;
    logic [2:0]                 chunk_lz [8];
    logic [5:0]                 zeros;
    logic [6:0]                 rank_wide;

    // Leading-zero count in two levels: within each byte, then across bytes.
    always_comb begin
        rest = s_tdata << BUCKET_BITS;
        for (int c = 0; c < 8; c++) begin
            chunk_nz[c] = |rest[c*8 +: 8];
            chunk_lz[c] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (rest[c*8+b]) begin
                    chunk_lz[c] = 3'(7 - b);
                end
            end
        end
        zeros = 6'd0;
        for (int c = 0; c < 8; c++) begin
            if (chunk_nz[c]) begin
                zeros = {3'(7 - c), chunk_lz[c]};
            end
        end
        if (rest == '0) begin
            rank_wide = 7'(REST_W + 1);
        end else begin
            rank_wide = {1'b0, zeros} + 7'd1;
        end
    end

    assign s_tready    = !queue_full && !clearing;
    assign push        = s_tvalid && s_tready;
    assign push_bucket = s_tdata[hll_pkg::HASH_W-1 -: BUCKET_BITS];
    assign push_rank   = rank_wide[hll_pkg::RANK_W-1:0];

endmodule

// ===== design/hll_fifo.sv =====
module hll_fifo #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             full,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      cnt_reg, cnt_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + (AW+1)'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout  = mem_reg[rd_ptr_reg];
    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);

endmodule

// ===== design/hll_back.sv =====
module hll_back #(
    parameter int BUCKET_BITS   = 11,
    parameter int FRACTION_BITS = 47
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_empty,
    input  logic [BUCKET_BITS-1:0]     q_bucket,
    input  logic [hll_pkg::RANK_W-1:0] q_rank,
    output logic                       q_pop,
    output logic                       clearing,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output hll_pkg::result_t           m_result
);

    localparam int DEPTH = 1 << BUCKET_BITS;
    localparam int SUM_W = BUCKET_BITS + FRACTION_BITS + 1;
    localparam int CNT_W = BUCKET_BITS + 1;
    localparam int RW    = hll_pkg::RANK_W;

    localparam logic [SUM_W-1:0] SUM_INIT = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [CNT_W-1:0] CNT_INIT = {1'b1, {(CNT_W-1){1'b0}}};

    function automatic logic [SUM_W-1:0] term_of(input logic [RW-1:0] r);
        logic [SUM_W-1:0] t;
        t = '0;
        if (7'(r) <= 7'(FRACTION_BITS)) begin
            t = SUM_W'(1) << (FRACTION_BITS - int'(r));
        end
        return t;
    endfunction

    logic                   clr_busy_reg, clr_busy_next;
    logic [BUCKET_BITS-1:0] clr_addr_reg, clr_addr_next;

    logic                   ex_valid_reg, ex_valid_next;
    logic [BUCKET_BITS-1:0] ex_bucket_reg;
    logic [RW-1:0]          ex_rank_reg;

    logic                   fwd_valid_reg, fwd_valid_next;
    logic [BUCKET_BITS-1:0] fwd_bucket_reg;
    logic [RW-1:0]          fwd_rank_reg;

    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic                   m_valid_reg, m_valid_next;
    hll_pkg::result_t       m_result_reg;

    logic [RW-1:0]          ram_rdata;
    logic [RW-1:0]          old_rank;
    logic [RW-1:0]          kept_rank;
    logic                   raised;
    logic                   commit;
    logic [SUM_W-1:0]       delta;
    logic                   ram_we;
    logic [BUCKET_BITS-1:0] ram_waddr;
    logic [RW-1:0]          ram_wdata;

    hll_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_rank_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (q_pop),
        .raddr (q_bucket),
        .rdata (ram_rdata)
    );

    // A read issued in the cycle of the previous commit misses that write, so the
    // last committed bucket is forwarded.
    assign old_rank  = (fwd_valid_reg && fwd_bucket_reg == ex_bucket_reg) ? fwd_rank_reg
                                                                           : ram_rdata;
    assign raised    = ex_rank_reg > old_rank;
    assign kept_rank = raised ? ex_rank_reg : old_rank;
    assign commit    = ex_valid_reg && (!m_valid_reg || m_tready);
    assign q_pop     = !q_empty && !clr_busy_reg && (!ex_valid_reg || commit);
    assign delta     = term_of(old_rank) - term_of(ex_rank_reg);

    assign ram_we    = clr_busy_reg || (commit && raised);
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : ex_bucket_reg;
    assign ram_wdata = clr_busy_reg ? '0 : ex_rank_reg;

    always_comb begin
        clr_busy_next  = clr_busy_reg;
        clr_addr_next  = clr_addr_reg;
        ex_valid_next  = ex_valid_reg;
        fwd_valid_next = fwd_valid_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg;

        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + BUCKET_BITS'(1);
            if (clr_addr_reg == BUCKET_BITS'(DEPTH - 1)) begin
                clr_busy_next = 1'b0;
            end
        end

        if (q_pop) begin
            ex_valid_next = 1'b1;
        end else if (commit) begin
            ex_valid_next = 1'b0;
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (commit) begin
            fwd_valid_next = 1'b1;
            m_valid_next   = 1'b1;
            if (raised) begin
                sum_next = sum_reg - delta;
                if (old_rank == '0 && cnt_reg != '0) begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            ex_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            sum_reg       <= SUM_INIT;
            cnt_reg       <= CNT_INIT;
            m_valid_reg   <= 1'b0;
        end else begin
            clr_busy_reg  <= clr_busy_next;
            clr_addr_reg  <= clr_addr_next;
            ex_valid_reg  <= ex_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ex_bucket_reg <= q_bucket;
            ex_rank_reg   <= q_rank;
        end
        if (commit) begin
            fwd_bucket_reg             <= ex_bucket_reg;
            fwd_rank_reg               <= kept_rank;
            m_result_reg.bucket_index  <= hll_pkg::BKT_OUT_W'(ex_bucket_reg);
            m_result_reg.new_rank      <= ex_rank_reg;
            m_result_reg.rank_raised   <= raised;
            m_result_reg.harmonic_sum  <= hll_pkg::SUM_OUT_W'(sum_next);
            m_result_reg.empty_count   <= hll_pkg::CNT_OUT_W'(cnt_next);
        end
    end

    assign clearing = clr_busy_reg;
    assign m_tvalid = m_valid_reg;
    assign m_result = m_result_reg;

endmodule

// ===== design/hyperloglog_sketch_update_unit.sv =====
// Channel  Direction  Word contents (lowest bits first)
// s_       in         hash_value[63:0]
// m_       out        bucket_index[10:0], new_rank[16:11], rank_raised[17],
//                     harmonic_sum[76:18], empty_count[88:77], zero pad to 96
//
// One hash is taken per cycle and one result leaves per cycle when m_tready stays high and the clear is done.
// A taken hash is written into the queue; the rank memory read then loads it into the
// compare stage, and the compare-and-update loads the output register that drives
// m_tvalid.
// After reset the rank memory is cleared one bucket a cycle, all 2^BUCKET_BITS buckets
// (2048 by default), while s_tready is low.
// With m_tready low, six words are held (output register, compare stage and the
// four-word queue) before s_tready drops.
module hyperloglog_sketch_update_unit #(
    parameter int BUCKET_BITS   = 11,
    parameter int FRACTION_BITS = 47
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hll_pkg::HASH_W-1:0]    s_tdata,   // hash_value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hll_pkg::M_TDATA_W-1:0] m_tdata    // bucket_index, new_rank,
                                                     // rank_raised, harmonic_sum,
                                                     // empty_count
);

    localparam int ENTRY_W = BUCKET_BITS + hll_pkg::RANK_W;

    logic                       queue_full;
    logic                       queue_empty;
    logic                       clearing;
    logic                       push;
    logic                       pop;
    logic [BUCKET_BITS-1:0]     push_bucket;
    logic [hll_pkg::RANK_W-1:0] push_rank;
    logic [ENTRY_W-1:0]         q_dout;
    hll_pkg::result_t           m_result;

    hll_front #(
        .BUCKET_BITS (BUCKET_BITS)
    ) u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .queue_full  (queue_full),
        .clearing    (clearing),
        .push        (push),
        .push_bucket (push_bucket),
        .push_rank   (push_rank)
    );

    hll_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (4)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     ({push_bucket, push_rank}),
        .pop     (pop),
        .dout    (q_dout),
        .full    (queue_full),
        .empty   (queue_empty)
    );

    hll_back #(
        .BUCKET_BITS   (BUCKET_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (queue_empty),
        .q_bucket (q_dout[ENTRY_W-1 -: BUCKET_BITS]),
        .q_rank   (q_dout[hll_pkg::RANK_W-1:0]),
        .q_pop    (pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {{hll_pkg::PAD_W{1'b0}}, m_result};

endmodule

// ===== design/hll_checker.sv =====
`include "assert_macros.svh"

module hll_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [hll_pkg::M_TDATA_W-1:0] m_tdata
);

    hll_pkg::result_t                  res;
    logic                              have_reg;
    logic [hll_pkg::SUM_OUT_W-1:0]     last_sum_reg;
    logic [hll_pkg::CNT_OUT_W-1:0]     last_cnt_reg;
    logic                              out_take;
    logic                              in_take;

    assign res      = m_tdata[hll_pkg::RES_W-1:0];
    assign out_take = m_tvalid && m_tready;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
        end else if (out_take) begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take) begin
            last_sum_reg <= res.harmonic_sum;
            last_cnt_reg <= res.empty_count;
        end
    end

    `ASSERT_IMPLY_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_IMPLY(a_clear_after_reset, aclk, aresetn, $past(!aresetn), !s_tready && !in_take)
    `ASSERT_IMPLY(a_rank_nonzero, aclk, aresetn, m_tvalid, res.new_rank != '0)
    `ASSERT_IMPLY(a_steady_totals, aclk, aresetn, out_take && have_reg && !res.rank_raised, res.harmonic_sum == last_sum_reg && res.empty_count == last_cnt_reg)

endmodule

bind hyperloglog_sketch_update_unit hll_checker u_hll_checker (.*);

// ===== tb/tb.sv =====
module tb;

    localparam int BUCKET_BITS   = 11;
    localparam int FRACTION_BITS = 47;
    localparam int BUCKET_COUNT  = 1 << BUCKET_BITS;
    localparam int REST_W        = hll_pkg::HASH_W - BUCKET_BITS;
    localparam int RANDOM_HASHES = 1550;
    localparam int HOLD_CYCLES   = 150;

    typedef struct packed {
        logic [hll_pkg::HASH_W-1:0] hash;
        logic                       known;
        hll_pkg::result_t           want;
    } stim_row_t;

    localparam int DIR_N = 18;

    // Only the first rows carry a typed-in result word; the rest go through the predictor.
    localparam stim_row_t DIRECTED [0:DIR_N-1] = '{
        '{hash: 64'h0, known: 1'b1,
          want: '{empty_count: 12'd2047, harmonic_sum: 59'd2047 << 47,
                  rank_raised: 1'b1, new_rank: 6'd54, bucket_index: 11'd0}},
        '{hash: 64'hFFFF_FFFF_FFFF_FFFF, known: 1'b1,
          want: '{empty_count: 12'd2046, harmonic_sum: (59'd2046 << 47) + (59'd1 << 46),
                  rank_raised: 1'b1, new_rank: 6'd1, bucket_index: 11'd2047}},
        '{hash: 64'hFFFF_FFFF_FFFF_FFFF, known: 1'b1,
          want: '{empty_count: 12'd2046, harmonic_sum: (59'd2046 << 47) + (59'd1 << 46),
                  rank_raised: 1'b0, new_rank: 6'd1, bucket_index: 11'd2047}},
        '{hash: {11'h7FF, 53'h40}, known: 1'b0, want: '0},
        '{hash: {11'h7FF, 53'h20}, known: 1'b0, want: '0},
        '{hash: {11'h7FF, 53'h0}, known: 1'b0, want: '0},
        '{hash: {11'h7FF, 53'h1}, known: 1'b0, want: '0},
        '{hash: {11'h005, 53'h1}, known: 1'b0, want: '0},
        '{hash: {11'h005, 53'h1}, known: 1'b0, want: '0},
        '{hash: {11'h005, 53'h1F_FFFF_FFFF_FFFF}, known: 1'b0, want: '0},
        '{hash: {11'h001, 53'h10_0000_0000_0000}, known: 1'b0, want: '0},
        '{hash: {11'h001, 53'h08_0000_0000_0000}, known: 1'b0, want: '0},
        '{hash: {11'h001, 53'h04_0000_0000_0000}, known: 1'b0, want: '0},
        '{hash: {11'h001, 53'hFF}, known: 1'b0, want: '0},
        '{hash: {11'h400, 53'h15_5555_5555_5555}, known: 1'b0, want: '0},
        '{hash: {11'h3FF, 53'h0A_AAAA_AAAA_AAAA}, known: 1'b0, want: '0},
        '{hash: {11'h2AA, 53'h100}, known: 1'b0, want: '0},
        '{hash: {11'h555, 53'h80}, known: 1'b0, want: '0}
    };

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [hll_pkg::HASH_W-1:0]    s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [hll_pkg::M_TDATA_W-1:0] m_tdata;

    logic [hll_pkg::RANK_W-1:0]    bucket_rank [BUCKET_COUNT];
    logic [hll_pkg::SUM_OUT_W-1:0] power_sum;
    logic [hll_pkg::CNT_OUT_W-1:0] empty_buckets;

    hll_pkg::result_t pending_results [$];
    hll_pkg::result_t seen_word;
    hll_pkg::result_t due_word;
    int               results_seen = 0;
    int               mismatches   = 0;
    int               hold_left    = 0;
    logic             hold_done    = 1'b0;

    hyperloglog_sketch_update_unit #(
        .BUCKET_BITS   (BUCKET_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Neither side idles while this window of results passes.
    function automatic logic steady_window();
        return results_seen >= 700 && results_seen < 1000;
    endfunction

    function automatic logic [hll_pkg::SUM_OUT_W-1:0] power_term(input int rank);
        if (rank > FRACTION_BITS)
            return '0;
        return {{(hll_pkg::SUM_OUT_W-1){1'b0}}, 1'b1} << (FRACTION_BITS - rank);
    endfunction

    function automatic int hash_rank(input logic [hll_pkg::HASH_W-1:0] hash);
        int rank;
        rank = REST_W + 1;
        // The highest set bit of the remaining bits is seen last and wins.
        for (int i = 0; i < REST_W; i++)
            if (hash[i])
                rank = REST_W - i;
        return rank;
    endfunction

    function automatic hll_pkg::result_t sketch_update(input logic [hll_pkg::HASH_W-1:0] hash);
        hll_pkg::result_t res;
        logic [hll_pkg::BKT_OUT_W-1:0] bkt;
        int rank;
        int prior;
        bkt = hash[hll_pkg::HASH_W-1 -: BUCKET_BITS];
        rank = hash_rank(hash);
        prior = bucket_rank[bkt];
        res.rank_raised = rank > prior;
        if (rank > prior) begin
            if (prior == 0)
                empty_buckets = empty_buckets - 1'b1;
            power_sum = power_sum - power_term(prior) + power_term(rank);
            bucket_rank[bkt] = hll_pkg::RANK_W'(rank);
        end
        res.bucket_index = bkt;
        res.new_rank     = hll_pkg::RANK_W'(rank);
        res.harmonic_sum = power_sum;
        res.empty_count  = empty_buckets;
        return res;
    endfunction

    // Most hashes carry a rank picked uniformly and aim at a few hot buckets, the edge buckets
    // or a random bucket, so that buckets get raised many times over; the rest are raw noise.
    function automatic logic [hll_pkg::HASH_W-1:0] random_hash();
        logic [hll_pkg::HASH_W-1:0] raw;
        logic [hll_pkg::BKT_OUT_W-1:0] bkt;
        logic [REST_W-1:0] rest;
        logic [REST_W-1:0] lead;
        int rank;
        int pick;
        raw = {$urandom, $urandom};
        if ($urandom_range(99) < 25)
            return raw;
        pick = $urandom_range(9);
        if (pick < 4)
            bkt = hll_pkg::BKT_OUT_W'($urandom_range(7) * 293);
        else if (pick < 6)
            bkt = $urandom_range(1) ? '1 : '0;
        else
            bkt = raw[hll_pkg::HASH_W-1 -: BUCKET_BITS];
        rank = $urandom_range(REST_W + 1, 1);
        if (rank == REST_W + 1) begin
            rest = '0;
        end else begin
            lead = {{(REST_W-1){1'b0}}, 1'b1} << (REST_W - rank);
            rest = lead | (raw[REST_W-1:0] & (lead - 1'b1));
        end
        return {bkt, rest};
    endfunction

    task automatic offer_hash(input logic [hll_pkg::HASH_W-1:0] hash, input logic known,
                              input hll_pkg::result_t typed);
        hll_pkg::result_t predicted;
        while (!steady_window() && $urandom_range(99) < 21) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= hash;
        do @(posedge aclk); while (!s_tready);
        predicted = sketch_update(hash);
        pending_results.push_back(known ? typed : predicted);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= 300 && !steady_window()) begin
            // Long hold-off so the output queue fills and s_tready drops.
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= steady_window() || ($urandom_range(99) >= 21);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_word = hll_pkg::result_t'(m_tdata[hll_pkg::RES_W-1:0]);
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                $error("result word with no hash pending: %h", seen_word);
                mismatches++;
            end else begin
                due_word = pending_results.pop_front();
                if (seen_word.bucket_index !== due_word.bucket_index) begin
                    $error("bucket_index: expected %0d, got %0d",
                           due_word.bucket_index, seen_word.bucket_index);
                    mismatches++;
                end
                if (seen_word.new_rank !== due_word.new_rank) begin
                    $error("new_rank: expected %0d, got %0d",
                           due_word.new_rank, seen_word.new_rank);
                    mismatches++;
                end
                if (seen_word.rank_raised !== due_word.rank_raised) begin
                    $error("rank_raised: expected %0d, got %0d",
                           due_word.rank_raised, seen_word.rank_raised);
                    mismatches++;
                end
                if (seen_word.harmonic_sum !== due_word.harmonic_sum) begin
                    $error("harmonic_sum: expected %h, got %h",
                           due_word.harmonic_sum, seen_word.harmonic_sum);
                    mismatches++;
                end
                if (seen_word.empty_count !== due_word.empty_count) begin
                    $error("empty_count: expected %0d, got %0d",
                           due_word.empty_count, seen_word.empty_count);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        for (int b = 0; b < BUCKET_COUNT; b++)
            bucket_rank[b] = '0;
        power_sum     = hll_pkg::SUM_OUT_W'(BUCKET_COUNT) << FRACTION_BITS;
        empty_buckets = hll_pkg::CNT_OUT_W'(BUCKET_COUNT);
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk); while (!aresetn);
        for (int r = 0; r < DIR_N; r++)
            offer_hash(DIRECTED[r].hash, DIRECTED[r].known, DIRECTED[r].want);
        for (int n = 0; n < RANDOM_HASHES; n++)
            offer_hash(random_hash(), 1'b0, '0);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("[hyperloglog_sketch_update_unit] OK");
        else
            $display("[hyperloglog_sketch_update_unit] ERROR");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("[hyperloglog_sketch_update_unit] ERROR");
        $finish;
    end

endmodule
